>>> design/tlpq_pkg.sv
`default_nettype none

package tlpq_pkg;

    // field widths of the stream payloads
    localparam int VALUE_W     = 32;
    localparam int CLASS_W     = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 7;
    localparam int NUM_CLASSES = 3;

    // packed stream widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // class codes
    localparam logic [CLASS_W-1:0] CLASS_HIGH   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LOW    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } tlpq_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } tlpq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } tlpq_stat_t;

endpackage

`default_nettype wire

>>> design/tlpq_ctrl.sv
`default_nettype none

module tlpq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output tlpq_pkg::tlpq_cmd_t    cmd,
    input  tlpq_pkg::tlpq_stat_t   stat
);
    import tlpq_pkg::*;

    tlpq_state_t state_reg;
    tlpq_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.read    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/tlpq_dp.sv
`default_nettype none

module tlpq_dp #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tlpq_pkg::tlpq_cmd_t                cmd,
    output tlpq_pkg::tlpq_stat_t               stat,
    input  logic [tlpq_pkg::IN_DATA_W-1:0]     in_data,
    input  logic [tlpq_pkg::IN_USER_W-1:0]     in_user,
    output logic [tlpq_pkg::OUT_DATA_W-1:0]    out_data,
    output logic [tlpq_pkg::OUT_USER_W-1:0]    out_user,
    output logic                               out_valid,
    input  logic                               out_ready
);
    import tlpq_pkg::*;

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DEPTH  = NUM_CLASSES * CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EXT_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    // captured request
    logic                  req_pop_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [CLASS_W-1:0]    class_reg;
    logic [STATUS_W-1:0]   status_reg;

    // per-class queue state
    logic [PTR_W-1:0] rptr_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] rptr_next [NUM_CLASSES];
    logic [PTR_W-1:0] wptr_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] wptr_next [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg   [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_next  [NUM_CLASSES];
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;

    // entry memory, one region of CAPACITY words per class
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    logic [EXT_W-1:0]   in_ext;
    logic [EXT_W-1:0]   rd_ext;
    logic [CLASS_W-1:0] in_class;
    logic               head_found;
    logic [CLASS_W-1:0] head_cls;
    logic [PTR_W-1:0]   head_rptr;
    logic [PTR_W-1:0]   cur_wptr;
    logic [ADDR_W-1:0]  head_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               is_full;
    logic               is_empty;
    logic               push_ok;
    logic               pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [CLASS_W-1:0] c,
                                                     input logic [PTR_W-1:0]   p);
        logic [ADDR_W-1:0] base;
        case (c)
            CLASS_HIGH:   base = '0;
            CLASS_MEDIUM: base = ADDR_W'(CAPACITY);
            default:      base = ADDR_W'(2 * CAPACITY);
        endcase
        return base + ADDR_W'(p);
    endfunction

    // input field decode, class code 3 folds into low
    assign in_ext   = EXT_W'(signed'(in_data[VALUE_W-1:0]));
    assign in_class = (in_user[2:1] > CLASS_LOW) ? CLASS_LOW : in_user[2:1];

    // head search: highest class with a stored entry
    always_comb
    begin
        head_found = 1'b1;
        head_cls   = CLASS_HIGH;
        if (cnt_reg[0] != '0)
        begin
            head_cls = CLASS_HIGH;
        end
        else if (cnt_reg[1] != '0)
        begin
            head_cls = CLASS_MEDIUM;
        end
        else if (cnt_reg[2] != '0)
        begin
            head_cls = CLASS_LOW;
        end
        else
        begin
            head_found = 1'b0;
        end
    end

    // pointer selection for the head read and the push write
    always_comb
    begin
        case (head_cls)
            CLASS_HIGH:   head_rptr = rptr_reg[0];
            CLASS_MEDIUM: head_rptr = rptr_reg[1];
            default:      head_rptr = rptr_reg[2];
        endcase
        case (class_reg)
            CLASS_HIGH:   cur_wptr = wptr_reg[0];
            CLASS_MEDIUM: cur_wptr = wptr_reg[1];
            default:      cur_wptr = wptr_reg[2];
        endcase
    end

    assign head_addr = entry_addr(head_cls, head_rptr);
    assign wr_addr   = entry_addr(class_reg, cur_wptr);

    // operation outcome
    assign is_full  = (total_reg >= CNT_W'(CAPACITY));
    assign is_empty = (total_reg == '0);
    assign push_ok  = cmd.exec && (req_pop_reg == REQ_PUSH) && !is_full;
    assign pop_ok   = cmd.exec && (req_pop_reg == REQ_POP) && !is_empty;

    // next queue state
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            rptr_next[c] = rptr_reg[c];
            wptr_next[c] = wptr_reg[c];
            cnt_next[c]  = cnt_reg[c];
            if (push_ok && class_reg == CLASS_W'(c))
            begin
                wptr_next[c] = ptr_inc(wptr_reg[c]);
                cnt_next[c]  = cnt_reg[c] + 1'b1;
            end
            if (pop_ok && head_cls == CLASS_W'(c))
            begin
                rptr_next[c] = ptr_inc(rptr_reg[c]);
                cnt_next[c]  = cnt_reg[c] - 1'b1;
            end
        end
        total_next = total_reg;
        if (push_ok)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            total_next = total_reg - 1'b1;
        end
    end

    // queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                rptr_reg[c] <= '0;
                wptr_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                rptr_reg[c] <= rptr_next[c];
                wptr_reg[c] <= wptr_next[c];
                cnt_reg[c]  <= cnt_next[c];
            end
            total_reg <= total_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and status
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_pop_reg <= in_user[0];
            value_reg   <= in_ext[DATA_WIDTH-1:0];
            class_reg   <= in_class;
        end
        if (cmd.exec)
        begin
            if (req_pop_reg == REQ_POP)
            begin
                status_reg <= is_empty ? STATUS_EMPTY : STATUS_OK;
            end
            else
            begin
                status_reg <= is_full ? STATUS_FULL : STATUS_OK;
            end
        end
    end

    // entry memory write and registered read
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[head_addr];
        end
    end

    assign rd_ext = EXT_W'(signed'(rd_data_reg));

    // result register load
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_user_reg           <= status_reg;
            out_data_reg[0]        <= head_found;
            out_data_reg[32:1]     <= head_found ? rd_ext[VALUE_W-1:0] : '0;
            out_data_reg[34:33]    <= head_found ? head_cls : CLASS_HIGH;
            out_data_reg[41:35]    <= OUT_CNT_W'(total_reg);
            out_data_reg[48:42]    <= OUT_CNT_W'(cnt_reg[0]);
            out_data_reg[55:49]    <= OUT_CNT_W'(cnt_reg[1]);
            out_data_reg[62:56]    <= OUT_CNT_W'(cnt_reg[2]);
            out_data_reg[63]       <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_user      = out_user_reg;

endmodule

`default_nettype wire

>>> design/three_level_priority_queue.sv
`default_nettype none

// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata value, tuser req_type + class
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata head + counts, tuser status
//
// each operation passes through capture on the accept edge, then queue update,
// registered read of the head entry from the single-port entry memory, result load.
// the result turns valid when it is loaded, and the next request can be accepted
// in the cycle after the load, so a waiting result does not block the next capture;
// the load stalls only while the result register is still full and not being taken.
// reset clears pointers, counts and handshake state; the entry memory is not cleared.

module three_level_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value[31:0]
    input  logic [tlpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[0], priority_class[2:1]
    input  logic [tlpq_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // head_valid[0], head_value[32:1], head_class[34:33], total_count[41:35],
    // high_count[48:42], medium_count[55:49], low_count[62:56], zero[63]
    output logic [tlpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [tlpq_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import tlpq_pkg::*;

    tlpq_cmd_t  cmd;
    tlpq_stat_t stat;

    // sequencing
    tlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // queue storage and result formatting
    tlpq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

>>> dv/tlpq_checker.sv
module tlpq_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // value[31:0]
    input  logic [tlpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[0], priority_class[2:1]
    input  logic [tlpq_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // head_valid[0], head_value[32:1], head_class[34:33], total_count[41:35],
    // high_count[48:42], medium_count[55:49], low_count[62:56], zero[63]
    input  logic [tlpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    input  logic [tlpq_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output int                               mismatch_count,
    output int                               pending_results,
    output int                               checked_results,
    output int                               refused_pushes,
    output int                               empty_pops,
    output int                               peak_fill
);

    timeunit 1ns;
    timeprecision 1ps;

    import tlpq_pkg::*;

    // one result as seen after an operation
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 head_valid;
        logic [VALUE_W-1:0]   head_value;
        logic [CLASS_W-1:0]   head_class;
        logic [OUT_CNT_W-1:0] total_cnt;
        logic [OUT_CNT_W-1:0] high_cnt;
        logic [OUT_CNT_W-1:0] med_cnt;
        logic [OUT_CNT_W-1:0] low_cnt;
        logic                 pad;
    } queue_view_t;

    // shadow copy of the queue contents
    logic [VALUE_W-1:0] class_store [NUM_CLASSES][CAPACITY];
    int                 rd_ptr     [NUM_CLASSES];
    int                 wr_ptr     [NUM_CLASSES];
    int                 class_fill [NUM_CLASSES];
    int                 fill_total;

    queue_view_t        view_q[$];

    int                 errs;
    int                 checked;
    int                 refused;
    int                 empties;
    int                 peak;

    // apply one request to the shadow queue and return the view after it
    function automatic queue_view_t apply_request(logic req, logic [VALUE_W-1:0] word,
                                                  logic [CLASS_W-1:0] cls_in);
        queue_view_t v;
        int          cls;
        int          head;
        v = '0;
        v.status = STATUS_OK;
        head = -1;
        if (req == REQ_PUSH) begin
            // class code 3 lands in the low class
            cls = (cls_in > CLASS_LOW) ? int'(CLASS_LOW) : int'(cls_in);
            if (fill_total >= CAPACITY) begin
                v.status = STATUS_FULL;
                refused++;
            end
            else begin
                class_store[cls][wr_ptr[cls]] = word;
                wr_ptr[cls] = (wr_ptr[cls] + 1) % CAPACITY;
                class_fill[cls]++;
                fill_total++;
            end
        end
        else if (fill_total == 0) begin
            v.status = STATUS_EMPTY;
            empties++;
        end
        else begin
            // remove from the highest non-empty class
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (head < 0 && class_fill[c] != 0) begin
                    head = c;
                end
            end
            rd_ptr[head] = (rd_ptr[head] + 1) % CAPACITY;
            class_fill[head]--;
            fill_total--;
            head = -1;
        end
        if (fill_total > peak) begin
            peak = fill_total;
        end
        // head after the operation
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (head < 0 && class_fill[c] != 0) begin
                head = c;
            end
        end
        if (head >= 0) begin
            v.head_valid = 1'b1;
            v.head_value = class_store[head][rd_ptr[head]];
            v.head_class = CLASS_W'(head);
        end
        v.total_cnt = OUT_CNT_W'(fill_total);
        v.high_cnt  = OUT_CNT_W'(class_fill[0]);
        v.med_cnt   = OUT_CNT_W'(class_fill[1]);
        v.low_cnt   = OUT_CNT_W'(class_fill[2]);
        return v;
    endfunction

    function automatic int field_diff(string name, logic [VALUE_W-1:0] want,
                                      logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // watch both channels, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n) begin
        queue_view_t want;
        queue_view_t got;
        if (!rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                rd_ptr[c]     = 0;
                wr_ptr[c]     = 0;
                class_fill[c] = 0;
            end
            fill_total = 0;
            view_q.delete();
            errs    = 0;
            checked = 0;
            refused = 0;
            empties = 0;
            peak    = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status     = m_axis_tuser[1:0];
                got.head_valid = m_axis_tdata[0];
                got.head_value = m_axis_tdata[32:1];
                got.head_class = m_axis_tdata[34:33];
                got.total_cnt  = m_axis_tdata[41:35];
                got.high_cnt   = m_axis_tdata[48:42];
                got.med_cnt    = m_axis_tdata[55:49];
                got.low_cnt    = m_axis_tdata[62:56];
                got.pad        = m_axis_tdata[63];
                if (view_q.size() == 0) begin
                    $error("result transfer with no prediction waiting: tdata 0x%0h",
                           m_axis_tdata);
                    errs++;
                end
                else begin
                    want = view_q.pop_front();
                    errs += field_diff("status", VALUE_W'(want.status),
                                       VALUE_W'(got.status));
                    errs += field_diff("head_valid", VALUE_W'(want.head_valid),
                                       VALUE_W'(got.head_valid));
                    errs += field_diff("head_value", want.head_value, got.head_value);
                    errs += field_diff("head_class", VALUE_W'(want.head_class),
                                       VALUE_W'(got.head_class));
                    errs += field_diff("total_count", VALUE_W'(want.total_cnt),
                                       VALUE_W'(got.total_cnt));
                    errs += field_diff("high_count", VALUE_W'(want.high_cnt),
                                       VALUE_W'(got.high_cnt));
                    errs += field_diff("medium_count", VALUE_W'(want.med_cnt),
                                       VALUE_W'(got.med_cnt));
                    errs += field_diff("low_count", VALUE_W'(want.low_cnt),
                                       VALUE_W'(got.low_cnt));
                    errs += field_diff("pad", VALUE_W'(want.pad), VALUE_W'(got.pad));
                    checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                view_q.push_back(apply_request(s_axis_tuser[0], s_axis_tdata,
                                               s_axis_tuser[2:1]));
            end
        end
        mismatch_count  <= errs;
        pending_results <= view_q.size();
        checked_results <= checked;
        refused_pushes  <= refused;
        empty_pops      <= empties;
        peak_fill       <= peak;
    end

endmodule

>>> dv/tb_three_level_priority_queue.sv
module tb_three_level_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import tlpq_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int ITEM_TARGET   = 1150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PRESSURE_AT   = 400;
    localparam int PRESSURE_HOLD = 250;

    // request mixes of a random segment
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [IN_USER_W-1:0]    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [OUT_USER_W-1:0]   m_axis_tuser;

    int mismatch_count;
    int pending_results;
    int checked_results;
    int refused_pushes;
    int empty_pops;
    int peak_fill;

    int items_sent;
    int gap_pct;
    bit pressure_done;
    int cycles;

    three_level_priority_queue #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tlpq_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .checked_results (checked_results),
        .refused_pushes  (refused_pushes),
        .empty_pops      (empty_pops),
        .peak_fill       (peak_fill)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // data words lean toward the extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // classes 0..2 evenly, the unused code 3 now and then
    function automatic logic [CLASS_W-1:0] pick_class();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return CLASS_HIGH;
        end
        if (r < 6) begin
            return CLASS_MEDIUM;
        end
        if (r < 9) begin
            return CLASS_LOW;
        end
        return 2'd3;
    endfunction

    // one request transfer, entered and left at a falling edge
    task automatic send_item(logic req, logic [VALUE_W-1:0] word, logic [CLASS_W-1:0] cls);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        s_axis_tuser  = {cls, req};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // result side: random stalls, quiet stretches, one long hold-off
    initial begin
        int gap_left;
        int pct;
        int phase;
        gap_left = 0;
        pct      = 0;
        phase    = 0;
        pressure_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!pressure_done && items_sent >= PRESSURE_AT) begin
                m_axis_tready = 1'b0;
                repeat (PRESSURE_HOLD) @(negedge clk);
                pressure_done = 1'b1;
            end
            if (phase == 0) begin
                pct   = pick_pct();
                phase = 64;
            end
            phase--;
            if (gap_left > 0) begin
                m_axis_tready = 1'b0;
                gap_left--;
            end
            else if ($urandom_range(0, 99) < pct) begin
                m_axis_tready = 1'b0;
                gap_left = idle_len() - 1;
            end
            else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int seg_idx;
        int seg_len;
        int mix;
        int push_pct;
        logic req;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        items_sent    = 0;
        gap_pct       = 0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, extreme words in every class, unused class code,
        // priority order on the way out, then empty again
        send_item(REQ_POP, 32'h1234_5678, 2'd3);
        send_item(REQ_PUSH, 32'h8000_0000, CLASS_LOW);
        send_item(REQ_PUSH, 32'h7fff_ffff, CLASS_MEDIUM);
        send_item(REQ_PUSH, 32'h0000_0000, CLASS_HIGH);
        send_item(REQ_PUSH, 32'hffff_ffff, 2'd3);
        send_item(REQ_PUSH, 32'h0000_0001, CLASS_HIGH);
        send_item(REQ_PUSH, 32'hffff_fffe, CLASS_MEDIUM);
        for (int k = 0; k < 6; k++) begin
            send_item(REQ_POP, $urandom, 2'($urandom_range(0, 3)));
        end
        send_item(REQ_POP, 32'hffff_ffff, CLASS_LOW);
        send_item(REQ_PUSH, 32'h5555_5555, CLASS_LOW);
        send_item(REQ_PUSH, 32'haaaa_aaaa, CLASS_HIGH);
        send_item(REQ_POP, 32'h0000_0000, CLASS_HIGH);
        send_item(REQ_POP, 32'h0000_0000, CLASS_HIGH);

        // random segments: first fill to overflow, then drain past empty
        seg_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (seg_idx == 0) begin
                mix = MIX_FILL;
            end
            else if (seg_idx == 1) begin
                mix = MIX_DRAIN;
            end
            else begin
                mix = $urandom_range(MIX_FILL, MIX_EVEN);
            end
            seg_len  = (seg_idx < 2) ? 110 : $urandom_range(20, 120);
            push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
            gap_pct  = (seg_idx < 2) ? 0 : pick_pct();
            for (int k = 0; k < seg_len && items_sent < ITEM_TARGET; k++) begin
                req = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
                send_item(req, pick_value(), pick_class());
            end
            seg_idx++;
        end
        s_axis_tvalid = 1'b0;

        // let every outstanding result come back
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests, checked %0d results, queue peaked at %0d of %0d",
                 items_sent, checked_results, peak_fill, CAPACITY);
        $display("%0d pushes refused on a full queue, %0d pops on an empty queue",
                 refused_pushes, empty_pops);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
